### src/lmgs_pkg.sv
// Shared constants, queue entry type and glyph font for the LED matrix scan shifter.
package lmgs_pkg;

  localparam int ROW_COUNT   = 8;
  localparam int ROW_W       = $clog2(ROW_COUNT);
  localparam int GLYPH_COUNT = 13;
  localparam int GLYPH_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = GLYPH_W'(12);
  localparam logic [7:0]         POINT_MASK_RESET = 8'h80;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               show_point;
  } entry_t;

  function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] glyph,
                                          input logic [ROW_W-1:0] row);
    logic [63:0] word;
    begin
      case (glyph)
        4'd0:    word = 64'h0000_3c42_423c_0000;
        4'd1:    word = 64'h0000_407e_4644_0000;
        4'd2:    word = 64'h0000_4e5a_5276_0000;
        4'd3:    word = 64'h0000_7e4a_4a42_0000;
        4'd4:    word = 64'h0000_107c_101e_0000;
        4'd5:    word = 64'h0000_7a4a_4a4e_0000;
        4'd6:    word = 64'h0000_7a4a_4a7e_0000;
        4'd7:    word = 64'h0000_060a_7a02_0000;
        4'd8:    word = 64'h0000_7e4a_4a7e_0000;
        4'd9:    word = 64'h0000_7e4a_4a6e_0000;
        4'd10:   word = 64'h0000_0008_0808_0800;
        4'd11:   word = 64'h0066_4242_427e_0001;
        default: word = 64'h0;
      endcase
      font_row = word[{row, 3'b000} +: 8];
    end
  endfunction

endpackage

### src/lmgs_front.sv
// Front end: accept glyph requests, map out-of-font indices to blank, and queue them.
module lmgs_front import lmgs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [GLYPH_W-1:0] glyph_index,
  input  logic               show_point,
  output logic               full,
  output entry_t             q_entry,
  output logic               q_valid,
  input  logic               q_take
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               wr_en;
  logic               rd_en;
  entry_t             classified;

  always_comb begin
    classified.show_point = show_point;
    if (({1'b0, glyph_index} >= (GLYPH_W + 1)'(GLYPH_COUNT)) || (glyph_index >= BLANK_GLYPH)) begin
      classified.glyph = BLANK_GLYPH;
    end else begin
      classified.glyph = glyph_index;
    end
  end

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = slots[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/lmgs_back.sv
// Back end: walk queued glyph rows/phases; register a transfer per cycle unless stalled.
module lmgs_back import lmgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] point_mask,
  input  entry_t     q_entry,
  input  logic       q_valid,
  output logic       q_take,
  input  logic       pop,
  output logic       empty,
  output logic       step_kind,
  output logic [7:0] shift_byte,
  output logic       last_step
);

  localparam logic [1:0]       PH_COL   = 2'd0;
  localparam logic [1:0]       PH_ROW   = 2'd1;
  localparam logic [1:0]       PH_LATCH = 2'd2;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

  logic [ROW_W-1:0] row;
  logic [1:0]       phase;
  logic             out_valid;
  logic             advance;
  logic             emit;
  logic             kind_next;
  logic [7:0]       byte_next;
  logic             last_next;
  logic [7:0]       glyph_byte;

  assign advance = !out_valid || pop;
  assign emit    = advance && q_valid;
  assign q_take  = emit && (row == ROW_LAST) && (phase == PH_LATCH);
  assign empty   = !out_valid;

  always_comb begin
    glyph_byte = font_row(q_entry.glyph, row);
    if ((row == ROW_LAST) && q_entry.show_point) begin
      glyph_byte = glyph_byte | point_mask;
    end
    kind_next = 1'b0;
    byte_next = 8'h00;
    last_next = 1'b0;
    case (phase)
      PH_COL: begin
        byte_next = ~(8'h01 << row);
      end
      PH_ROW: begin
        byte_next = glyph_byte;
      end
      PH_LATCH: begin
        kind_next = 1'b1;
        last_next = (row == ROW_LAST);
      end
      default: begin
        byte_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      phase     <= PH_COL;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      if (phase == PH_LATCH) begin
        phase <= PH_COL;
        row   <= (row == ROW_LAST) ? '0 : row + 1'b1;
      end else begin
        phase <= phase + 1'b1;
      end
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      step_kind  <= kind_next;
      shift_byte <= byte_next;
      last_step  <= last_next;
    end
  end

endmodule

### src/led_matrix_glyph_scan_shifter_core.sv
// A glyph pushed into an empty queue is written to a slot, then the back end registers
// its first transfer. Each glyph gives 24 transfers, one per cycle unless stalled;
// the row/phase sequencer sets the rate; queued glyphs follow each other with no gap.
// Reset (rst, synchronous): queue and output empty, sequencer at row 0, point_mask = 0x80.
// Configuration is always ready; write point_mask only while no glyph is in flight.
module led_matrix_glyph_scan_shifter_core import lmgs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [GLYPH_W-1:0] glyph_index,
  input  logic               show_point,
  output logic               empty,
  input  logic               pop,
  output logic               step_kind,
  output logic [7:0]         shift_byte,
  output logic               last_step,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic [7:0] point_mask;
  entry_t     q_entry;
  logic       q_valid;
  logic       q_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_mask <= POINT_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      point_mask <= cfg_data;
    end
  end

  lmgs_front #(.DEPTH(DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .glyph_index (glyph_index),
    .show_point  (show_point),
    .full        (full),
    .q_entry     (q_entry),
    .q_valid     (q_valid),
    .q_take      (q_take)
  );

  lmgs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .point_mask (point_mask),
    .q_entry    (q_entry),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .pop        (pop),
    .empty      (empty),
    .step_kind  (step_kind),
    .shift_byte (shift_byte),
    .last_step  (last_step)
  );

  a_last_is_latch: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_step) |-> step_kind)
    else $error("last transfer of a glyph is not a latch");

  a_latch_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && step_kind) |-> (shift_byte == 8'h00))
    else $error("latch transfer carries a nonzero byte");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("queue or output not empty after reset");

  a_take_on_latch: assert property (@(posedge clk) disable iff (rst)
    q_take |=> (!empty && step_kind && last_step))
    else $error("glyph retired without its final latch");

endmodule

### bench/tb_led_matrix_glyph_scan_shifter_core.sv
// Self-checking bench for the LED matrix glyph scan shifter: queued glyph jobs against a scan predictor.
module tb_led_matrix_glyph_scan_shifter_core;
  import lmgs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 60;

  typedef enum logic {STEP_SHIFT = 1'b0, STEP_LATCH = 1'b1} step_kind_e;
  typedef enum logic [1:0] {JOB_GLYPH, JOB_MASK, JOB_DRAIN} job_kind_e;
  typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_SLOW} pop_mode_e;

  typedef struct {
    job_kind_e          kind;
    logic [GLYPH_W-1:0] glyph;
    logic               point;
    logic [7:0]         mask;
  } glyph_job_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } scan_step_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [GLYPH_W-1:0] glyph_index = '0;
  logic               show_point = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic               step_kind;
  logic [7:0]         shift_byte;
  logic               last_step;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;

  glyph_job_t glyph_jobs[$];
  scan_step_t scan_steps_due[$];
  scan_step_t want;
  logic [7:0] point_mask_model = POINT_MASK_RESET;
  logic       push_taken = 1'b0;
  logic       cfg_taken = 1'b0;
  logic       next_push;
  logic       next_cfg;
  int         burst_left = 1;
  int         gap_left = 0;
  int         pop_left = 0;
  pop_mode_e  pop_mode = POP_ALWAYS;
  int         cycle_count = 0;
  int         error_count = 0;
  int         glyphs_sent = 0;
  int         steps_checked = 0;
  int         mask_writes = 0;

  led_matrix_glyph_scan_shifter_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .glyph_index(glyph_index),
    .show_point (show_point),
    .empty      (empty),
    .pop        (pop),
    .step_kind  (step_kind),
    .shift_byte (shift_byte),
    .last_step  (last_step),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Rows packed with row 0 in the top byte.
  function automatic logic [63:0] glyph_rows(input logic [GLYPH_W-1:0] glyph);
    case (glyph)
      4'd0:    glyph_rows = 64'h0000_3c42_423c_0000;
      4'd1:    glyph_rows = 64'h0000_4446_7e40_0000;
      4'd2:    glyph_rows = 64'h0000_7652_5a4e_0000;
      4'd3:    glyph_rows = 64'h0000_424a_4a7e_0000;
      4'd4:    glyph_rows = 64'h0000_1e10_7c10_0000;
      4'd5:    glyph_rows = 64'h0000_4e4a_4a7a_0000;
      4'd6:    glyph_rows = 64'h0000_7e4a_4a7a_0000;
      4'd7:    glyph_rows = 64'h0000_027a_0a06_0000;
      4'd8:    glyph_rows = 64'h0000_7e4a_4a7e_0000;
      4'd9:    glyph_rows = 64'h0000_6e4a_4a7e_0000;
      4'd10:   glyph_rows = 64'h0008_0808_0800_0000;
      4'd11:   glyph_rows = 64'h0100_7e42_4242_6600;
      default: glyph_rows = 64'h0;
    endcase
  endfunction

  task automatic predict_glyph_scan(input logic [GLYPH_W-1:0] glyph, input logic point);
    logic [63:0] rows;
    logic [7:0]  col_sel;
    logic [7:0]  row_data;
    rows = (glyph >= GLYPH_COUNT || glyph >= BLANK_GLYPH) ? 64'h0 : glyph_rows(glyph);
    for (int r = 0; r < ROW_COUNT; r++) begin
      col_sel  = ~(8'd1 << r);
      row_data = rows[63 - 8 * r -: 8];
      if (r == ROW_COUNT - 1 && point) begin
        row_data = row_data | point_mask_model;
      end
      scan_steps_due.push_back('{STEP_SHIFT, col_sel, 1'b0});
      scan_steps_due.push_back('{STEP_SHIFT, row_data, 1'b0});
      scan_steps_due.push_back('{STEP_LATCH, 8'h00, (r == ROW_COUNT - 1)});
    end
  endtask

  task automatic add_glyph(input logic [GLYPH_W-1:0] glyph, input logic point);
    glyph_jobs.push_back('{JOB_GLYPH, glyph, point, 8'h00});
  endtask

  task automatic add_mask(input logic [7:0] mask);
    glyph_jobs.push_back('{JOB_MASK, '0, 1'b0, mask});
  endtask

  task automatic add_drain();
    glyph_jobs.push_back('{JOB_DRAIN, '0, 1'b0, 8'h00});
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_glyph_scan(glyph_index, show_point);
        push_taken = 1'b1;
        glyphs_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        point_mask_model = cfg_data;
        cfg_taken = 1'b1;
        mask_writes++;
      end
    end
  end

  // Drive jobs in bursts; hold each transfer until taken.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_push = push && !push_taken;
      next_cfg  = cfg_valid && !cfg_taken;
      push_taken = 1'b0;
      cfg_taken  = 1'b0;
      if (!next_push && !next_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (glyph_jobs.size() != 0) begin
          case (glyph_jobs[0].kind)
            JOB_GLYPH: begin
              next_push = 1'b1;
              glyph_index <= glyph_jobs[0].glyph;
              show_point <= glyph_jobs[0].point;
              void'(glyph_jobs.pop_front());
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
              end
            end
            JOB_MASK: begin
              if (scan_steps_due.size() == 0) begin
                next_cfg = 1'b1;
                cfg_data <= glyph_jobs[0].mask;
                void'(glyph_jobs.pop_front());
              end
            end
            default: begin
              if (scan_steps_due.size() == 0) begin
                void'(glyph_jobs.pop_front());
              end
            end
          endcase
        end
      end
      push <= next_push;
      cfg_valid <= next_cfg;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_left <= 0) begin
        pop_mode = pop_mode_e'($urandom_range(0, 2));
        pop_left = $urandom_range(16, 96);
      end
      pop_left--;
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        default:    pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      steps_checked++;
      if (scan_steps_due.size() == 0) begin
        error_count++;
        $error("unexpected transfer: step_kind %0d shift_byte %02h last_step %0d",
               step_kind, shift_byte, last_step);
      end else begin
        want = scan_steps_due.pop_front();
        if (step_kind !== want.kind) begin
          error_count++;
          $error("step_kind expected %0d actual %0d", want.kind, step_kind);
        end
        if (shift_byte !== want.data) begin
          error_count++;
          $error("shift_byte expected %02h actual %02h", want.data, shift_byte);
        end
        if (last_step !== want.last) begin
          error_count++;
          $error("last_step expected %0d actual %0d", want.last, last_step);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_led_matrix_glyph_scan_shifter_core: errors");
      $finish;
    end
  end

  initial begin
    for (int g = 0; g < 16; g++) begin
      add_glyph(GLYPH_W'(g), g[0]);
    end
    add_mask(8'hff);
    add_glyph(4'd8, 1'b1);
    add_glyph(4'd13, 1'b1);
    add_mask(8'h00);
    add_glyph(4'd0, 1'b1);
    add_glyph(4'd11, 1'b0);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       add_mask(8'h01);
        1:       add_mask(POINT_MASK_RESET);
        2:       add_mask(8'hff);
        default: add_mask(8'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) begin
          add_drain();
        end
        add_glyph(GLYPH_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (glyph_jobs.size() != 0 || push || cfg_valid) @(posedge clk);
    while (scan_steps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d glyphs (all 16 indices, point on and off), %0d transfers checked,",
             glyphs_sent, steps_checked);
    $display("and %0d point_mask writes including 0x00, 0x01, 0x80 and 0xff", mask_writes);
    if (error_count == 0) begin
      $display("tb_led_matrix_glyph_scan_shifter_core: clean");
    end else begin
      $display("tb_led_matrix_glyph_scan_shifter_core: errors");
    end
    $finish;
  end

endmodule
